>>> rtl/dssm_pkg.sv
// Shared types and constants for the two-stacks-in-one-memory core.
package dssm_pkg;

    // Default configuration of the shared memory.
    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the item fields.
    localparam int OUT_WIDTH  = 32;
    localparam int PUSH_WIDTH = 32;

    // Requested operation of an input item.
    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_LIST = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // Status code of a result item.
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_LIST_RD,
        S_LIST_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_cmd;
        logic    do_push;
        logic    rd_pop;
        logic    rd_list;
        logic    list_clr;
        logic    list_inc;
        logic    emit;
        status_t emit_status;
        logic    emit_data;
        logic    emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    is_full;
        logic    is_empty;
        logic    list_last;
        logic    out_free;
    } dp_sts_t;

endpackage

>>> rtl/dual_stack_shared_memory_core.sv
// Push: memory written unless full, result registered from the execute state. Pop: the single registered
// memory read port is read in the execute state, the result registered from pop-wait. List: each entry
// is read in the read state, registered from the wait state. Push, pop and list hold input until their
// last result is registered; a pending result waits in the output register while the next item is accepted.
// Reset (aresetn low, synchronous) empties both stacks; memory contents are not cleared.
module dual_stack_shared_memory_core #(
    parameter int DEPTH      = dssm_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dssm_pkg::DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic                            s_stack_select,
    input  logic [dssm_pkg::PUSH_WIDTH-1:0] s_push_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dssm_pkg::OUT_WIDTH-1:0]  m_out_value,
    output logic [1:0]                      m_status,
    output logic                            m_last
);
    import dssm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer.
    dssm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Memory, counts and result register.
    dssm_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_action       (s_action),
        .s_stack_select (s_stack_select),
        .s_push_value   (s_push_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_status       (m_status),
        .m_last         (m_last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

>>> rtl/dssm_ctrl.sv
// Controller state machine that sequences push, pop and list items.
module dssm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dssm_pkg::dp_sts_t sts,
    output dssm_pkg::dp_cmd_t cmd
);
    import dssm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.action)
                    ACT_PUSH: begin
                        if (sts.out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    ACT_POP: begin
                        if (!sts.is_empty) begin
                            state_next = S_POP_WAIT;
                        end else if (sts.out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    ACT_LIST: begin
                        if (!sts.is_empty) begin
                            state_next = S_LIST_RD;
                        end else if (sts.out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP_WAIT: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD: begin
                state_next = S_LIST_WAIT;
            end
            S_LIST_WAIT: begin
                if (sts.out_free) begin
                    state_next = sts.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic: handshake and datapath commands.
    always_comb begin
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.emit_status = STS_OK;
        case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.latch_cmd = s_valid;
            end
            S_EXEC: begin
                case (sts.action)
                    ACT_PUSH: begin
                        if (sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.do_push     = !sts.is_full;
                            cmd.emit_status = sts.is_full ? STS_FULL : STS_OK;
                        end
                    end
                    ACT_POP: begin
                        if (!sts.is_empty) begin
                            cmd.rd_pop = 1'b1;
                        end else if (sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = STS_EMPTY;
                        end
                    end
                    ACT_LIST: begin
                        if (!sts.is_empty) begin
                            cmd.list_clr = 1'b1;
                        end else if (sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = STS_EMPTY;
                        end
                    end
                    default: begin
                        cmd.emit = 1'b0;
                    end
                endcase
            end
            S_POP_WAIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_data = 1'b1;
                    cmd.emit_last = 1'b1;
                end
            end
            S_LIST_RD: begin
                cmd.rd_list = 1'b1;
            end
            S_LIST_WAIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_data = 1'b1;
                    cmd.emit_last = sts.list_last;
                    cmd.list_inc  = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/dssm_datapath.sv
// Datapath: shared memory, stack counts, list index and result register.
module dssm_datapath #(
    parameter int DEPTH      = dssm_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dssm_pkg::DATA_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [1:0]                      s_action,
    input  logic                            s_stack_select,
    input  logic [dssm_pkg::PUSH_WIDTH-1:0] s_push_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dssm_pkg::OUT_WIDTH-1:0]  m_out_value,
    output logic [1:0]                      m_status,
    output logic                            m_last,
    input  dssm_pkg::dp_cmd_t               cmd,
    output dssm_pkg::dp_sts_t               sts
);
    import dssm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Latched item.
    action_t               action_reg;
    logic                  sel_reg;
    logic [DATA_WIDTH-1:0] value_reg;

    // Stack counts and list index.
    logic [CW-1:0] lower_count_reg;
    logic [CW-1:0] upper_count_reg;
    logic [CW-1:0] idx_reg;

    // Shared memory and its registered read port.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Result register.
    logic                 m_valid_reg;
    logic [OUT_WIDTH-1:0] out_value_reg;
    status_t              status_reg;
    logic                 last_reg;

    logic [63:0]           push_ext;
    logic [CW:0]           total_count;
    logic [CW-1:0]         sel_count;
    logic [CW-1:0]         push_addr;
    logic [CW-1:0]         pop_addr;
    logic [CW-1:0]         list_addr;
    logic [CW-1:0]         rd_addr;
    logic signed [63:0]    rd_ext;

    // Item latch; the pushed word keeps its low DATA_WIDTH bits.
    assign push_ext = {32'd0, s_push_value};

    always_ff @(posedge aclk) begin
        if (cmd.latch_cmd) begin
            action_reg <= action_t'(s_action);
            sel_reg    <= s_stack_select;
            value_reg  <= push_ext[DATA_WIDTH-1:0];
        end
    end

    // Occupancy checks: both stacks together and the selected stack.
    assign total_count = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign sel_count   = sel_reg ? upper_count_reg : lower_count_reg;

    // Memory addresses; the upper stack is indexed down from the last entry.
    assign push_addr = sel_reg ? (CW'(DEPTH - 1) - upper_count_reg) : lower_count_reg;
    assign pop_addr  = sel_reg ? (CW'(DEPTH) - upper_count_reg)
                               : (lower_count_reg - CW'(1));
    assign list_addr = sel_reg ? (CW'(DEPTH - 1) - idx_reg) : idx_reg;
    assign rd_addr   = cmd.rd_pop ? pop_addr : list_addr;

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.do_push) begin
            mem[push_addr[AW-1:0]] <= value_reg;
        end
        if (cmd.rd_pop || cmd.rd_list) begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // Stack counts and list index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end else if (cmd.do_push) begin
            if (sel_reg) begin
                upper_count_reg <= upper_count_reg + CW'(1);
            end else begin
                lower_count_reg <= lower_count_reg + CW'(1);
            end
        end else if (cmd.rd_pop) begin
            if (sel_reg) begin
                upper_count_reg <= upper_count_reg - CW'(1);
            end else begin
                lower_count_reg <= lower_count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.list_clr) begin
            idx_reg <= '0;
        end else if (cmd.list_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    // Read word sign-extended from DATA_WIDTH bits.
    assign rd_ext = 64'(signed'(rd_data_reg));

    // Result register; the controller emits only when it is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_value_reg <= cmd.emit_data ? rd_ext[OUT_WIDTH-1:0] : '0;
            status_reg    <= cmd.emit_status;
            last_reg      <= cmd.emit_last;
        end
    end

    // Status back to the controller.
    always_comb begin
        sts.action    = action_reg;
        sts.is_full   = (total_count >= (CW + 1)'(DEPTH));
        sts.is_empty  = (sel_count == '0);
        sts.list_last = ((idx_reg + CW'(1)) == sel_count);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = out_value_reg;
    assign m_status    = status_reg;
    assign m_last      = last_reg;

endmodule
